@@ design/text_glyph_renderer_defines.svh @@
// Assertion macros shared by the character generator.
`ifndef TEXT_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_GLYPH_RENDERER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define TGR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define TGR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tgr_pkg.sv @@
// Types, constants and the 5x7 font for the character generator.
package tgr_pkg;

	localparam logic [1:0] REQ_SET_CURSOR = 2'd0;
	localparam logic [1:0] REQ_DRAW_CHAR  = 2'd1;
	localparam logic [1:0] REQ_DRAW_NUM   = 2'd2;

	localparam logic [7:0] FIRST_CODE = 8'd32;
	localparam logic [7:0] LAST_CODE  = 8'd90;
	localparam logic [7:0] CODE_MINUS = 8'h2D;
	localparam logic [7:0] CODE_ZERO  = 8'h30;

	// Reciprocal of ten: floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for any 32-bit x.
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	localparam logic [3:0] MAX_DIGIT_IDX = 4'd9;
	localparam logic [3:0] NUM_DIGITS    = 4'd10;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         new_column;
		logic [7:0]         new_page;
		logic [7:0]         char_code;
		logic signed [31:0] number_value;
	} req_t;

	typedef struct packed {
		logic [7:0] target_page;
		logic [7:0] start_column;
		logic [7:0] glyph_col0;
		logic [7:0] glyph_col1;
		logic [7:0] glyph_col2;
		logic [7:0] glyph_col3;
		logic [7:0] glyph_col4;
		logic [5:0] write_mask;
		logic       last_char;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR,
		ST_MUL,
		ST_FIX,
		ST_SIGN,
		ST_DIGIT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SEL_CHAR,
		SEL_MINUS,
		SEL_DIGIT
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      set_cursor;
		logic      mul;
		logic      fix;
		logic      emit;
		emit_sel_t sel;
		logic      last;
	} cmd_t;

	typedef struct packed {
		logic       out_free;
		logic       div_done;
		logic       neg;
		logic [3:0] ptr;
	} stat_t;

	// Column 0 sits in the most significant byte.
	typedef logic [0:4][7:0] glyph_t;

	localparam glyph_t FONT_ROM [0:58] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_56_20_50, 40'h00_08_07_03_00,
		40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h2A_1C_7F_1C_2A, 40'h08_08_3E_08_08,
		40'h00_80_70_30_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00, 40'h20_10_08_04_02,
		40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h72_49_49_49_46, 40'h21_41_49_4D_33,
		40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_31, 40'h41_21_11_09_07,
		40'h36_49_49_49_36, 40'h46_49_49_29_1E, 40'h00_00_14_00_00, 40'h00_40_34_00_00,
		40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_59_09_06,
		40'h3E_41_5D_59_4E, 40'h7C_12_11_12_7C, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
		40'h7F_41_41_41_3E, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_41_51_73,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
		40'h7F_40_40_40_40, 40'h7F_02_1C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
		40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h26_49_49_49_32,
		40'h03_01_7F_01_03, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
		40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_59_49_4D_43
	};

	// Map a character code to its font columns; codes without a glyph draw a space.
	function automatic glyph_t glyph_lookup(logic [7:0] code);
		logic [7:0] idx;
		idx = (code < FIRST_CODE || code > LAST_CODE) ? 8'd0 : code - FIRST_CODE;
		return FONT_ROM[idx[5:0]];
	endfunction

endpackage

@@ design/tgr_req_if.sv @@
// Request channel: valid/ready handshake carrying one request.
interface tgr_req_if;
	logic          valid;
	logic          ready;
	tgr_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ design/tgr_res_if.sv @@
// Result channel: valid/ready handshake carrying one drawn character.
interface tgr_res_if;
	logic          valid;
	logic          ready;
	tgr_pkg::res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ design/text_glyph_renderer.sv @@
// Top level of the 5x7 character generator for a page-organized monochrome display.
//
// Channels: req (sink) takes one request per transaction: set cursor, draw a character,
// or draw a signed 32-bit number in decimal. res (source) delivers one transaction per
// drawn character: page, start column, five font column bytes, a six-bit in-buffer mask
// (five glyph columns, then the blank spacer) and last_char on the request's final one.
// Timing: req is ready only while the controller is idle. A set cursor is applied on
// acceptance. A character is emitted from the CHAR state into the result register.
// A number runs a multiply by the reciprocal of ten and a remainder fix-up per digit,
// then emits one result per character, sign included. The single result register lets
// the next request in while the last result waits. Stall: while res is stalled with a
// result pending, emission holds; digit extraction runs on. Reset clears the cursor to
// column 0, page 0 and empties the result register; the digit store is written before
// every read and needs no clearing.
module text_glyph_renderer #(
	parameter int DISPLAY_COLUMNS = 128,
	parameter int DISPLAY_PAGES   = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	tgr_req_if.sink   req,
	tgr_res_if.source res
);

	`include "text_glyph_renderer_defines.svh"

	tgr_pkg::cmd_t  cmd;
	tgr_pkg::stat_t st;

	// Sequence the work: intake, divide loop, sign, then digits most significant first.
	tgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.payload.req_type),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Hold the cursor, extract digits and build each result transaction.
	tgr_dp #(
		.DISPLAY_COLUMNS (DISPLAY_COLUMNS),
		.DISPLAY_PAGES   (DISPLAY_PAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.payload),
		.cmd       (cmd),
		.st        (st),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res_data  (res.payload)
	);

	// Never overwrite a result that is still waiting to be taken.
	`TGR_ASSERT_ALWAYS(a_emit_free, !cmd.emit || st.out_free, "emission over a pending result")
	// The digit pointer never exceeds ten, the depth of the digit store.
	`TGR_ASSERT_ALWAYS(a_ptr_range, st.ptr <= tgr_pkg::NUM_DIGITS, "digit pointer out of range")
	// Every multiply is followed by its remainder fix-up.
	`TGR_ASSERT_NEXT(a_mul_fix, cmd.mul, cmd.fix, "multiply not followed by fix-up")
	// A final character returns the controller to intake.
	`TGR_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, req.ready, "not idle after last char")

endmodule

@@ design/tgr_ctrl.sv @@
// Controller state machine: sequences request intake, digit extraction and emission.
module tgr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic [1:0]     req_type,
	output logic           req_ready,
	input  tgr_pkg::stat_t st,
	output tgr_pkg::cmd_t  cmd
);

	tgr_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.sel   = tgr_pkg::SEL_CHAR;
		unique case (state_q)
			tgr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					priority case (req_type)
						tgr_pkg::REQ_SET_CURSOR: cmd.set_cursor = 1'b1;
						tgr_pkg::REQ_DRAW_CHAR:  state_d = tgr_pkg::ST_CHAR;
						tgr_pkg::REQ_DRAW_NUM:   state_d = tgr_pkg::ST_MUL;
						default:                 state_d = tgr_pkg::ST_IDLE;
					endcase
				end
			end
			tgr_pkg::ST_CHAR: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = tgr_pkg::SEL_CHAR;
					cmd.last = 1'b1;
					state_d  = tgr_pkg::ST_IDLE;
				end
			end
			tgr_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = tgr_pkg::ST_FIX;
			end
			tgr_pkg::ST_FIX: begin
				cmd.fix = 1'b1;
				if (st.div_done) begin
					state_d = st.neg ? tgr_pkg::ST_SIGN : tgr_pkg::ST_DIGIT;
				end else begin
					state_d = tgr_pkg::ST_MUL;
				end
			end
			tgr_pkg::ST_SIGN: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = tgr_pkg::SEL_MINUS;
					state_d  = tgr_pkg::ST_DIGIT;
				end
			end
			tgr_pkg::ST_DIGIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = tgr_pkg::SEL_DIGIT;
					cmd.last = (st.ptr == 4'd1);
					if (st.ptr == 4'd1) begin
						state_d = tgr_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = tgr_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ design/tgr_dp.sv @@
// Datapath: cursor, divide-by-ten digit extraction, digit store, font lookup, result register.
module tgr_dp #(
	parameter int DISPLAY_COLUMNS = 128,
	parameter int DISPLAY_PAGES   = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tgr_pkg::req_t  req_data,
	input  tgr_pkg::cmd_t  cmd,
	output tgr_pkg::stat_t st,
	output logic           res_valid,
	input  logic           res_ready,
	output tgr_pkg::res_t  res_data
);

	logic [7:0]  cursor_col_q;
	logic [7:0]  cursor_page_q;
	logic [7:0]  char_q;
	logic        neg_q;
	logic [31:0] mag_q;
	logic [63:0] prod_q;
	logic [3:0]  ptr_q;
	logic [3:0]  digit_mem [0:9];
	logic        res_valid_q;
	tgr_pkg::res_t res_q;

	logic [31:0]     raw;
	logic [31:0]     quot;
	logic [3:0]      q10_lo;
	logic [3:0]      rem;
	logic [3:0]      rd_ptr;
	logic [7:0]      code;
	tgr_pkg::glyph_t glyph;
	logic [5:0]      mask;
	logic [8:0]      col_sum;
	logic [8:0]      col_adv;
	logic [7:0]      next_col;
	logic            page_ok;

	assign raw    = req_data.number_value;
	assign quot   = {3'd0, prod_q[63:tgr_pkg::RECIP_SHIFT]};
	// Only the low nibble of quot * 10 matters since the remainder is below ten.
	assign q10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
	assign rem    = mag_q[3:0] - q10_lo;
	assign rd_ptr = ptr_q - 4'd1;

	assign st.out_free = !res_valid_q || res_ready;
	assign st.div_done = (quot == 32'd0) || (ptr_q == tgr_pkg::MAX_DIGIT_IDX);
	assign st.neg      = neg_q;
	assign st.ptr      = ptr_q;

	always_comb begin
		unique case (cmd.sel)
			tgr_pkg::SEL_CHAR:  code = char_q;
			tgr_pkg::SEL_MINUS: code = tgr_pkg::CODE_MINUS;
			tgr_pkg::SEL_DIGIT: code = tgr_pkg::CODE_ZERO + {4'd0, digit_mem[rd_ptr]};
			default:            code = tgr_pkg::FIRST_CODE;
		endcase
	end

	assign glyph   = tgr_pkg::glyph_lookup(code);
	assign page_ok = cursor_page_q < 8'(DISPLAY_PAGES);

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			col_sum = {1'b0, cursor_col_q} + 9'(j);
			mask[j] = page_ok && (col_sum < 9'(DISPLAY_COLUMNS));
		end
	end

	// Advance by one cell, clamp at the right edge; hold a cursor already past it.
	always_comb begin
		col_adv  = {1'b0, cursor_col_q} + 9'd6;
		next_col = cursor_col_q;
		if ({1'b0, cursor_col_q} < 9'(DISPLAY_COLUMNS)) begin
			next_col = (col_adv > 9'(DISPLAY_COLUMNS)) ? 8'(DISPLAY_COLUMNS) : col_adv[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q  <= '0;
			cursor_page_q <= '0;
			ptr_q         <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cmd.set_cursor) begin
				cursor_col_q  <= req_data.new_column;
				cursor_page_q <= req_data.new_page;
			end else if (cmd.emit) begin
				cursor_col_q <= next_col;
			end
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.fix) begin
				ptr_q <= ptr_q + 4'd1;
			end else if (cmd.emit && cmd.sel == tgr_pkg::SEL_DIGIT) begin
				ptr_q <= rd_ptr;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= req_data.char_code;
			neg_q  <= raw[31];
			mag_q  <= raw[31] ? (32'd0 - raw) : raw;
		end else if (cmd.fix) begin
			mag_q <= quot;
		end
		if (cmd.mul) begin
			prod_q <= mag_q * tgr_pkg::RECIP10;
		end
		if (cmd.fix) begin
			digit_mem[ptr_q] <= rem;
		end
		if (cmd.emit) begin
			res_q.target_page  <= cursor_page_q;
			res_q.start_column <= cursor_col_q;
			res_q.glyph_col0   <= glyph[0];
			res_q.glyph_col1   <= glyph[1];
			res_q.glyph_col2   <= glyph[2];
			res_q.glyph_col3   <= glyph[3];
			res_q.glyph_col4   <= glyph[4];
			res_q.write_mask   <= mask;
			res_q.last_char    <= cmd.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

@@ test/tb_text_glyph_renderer.sv @@
// Self-checking testbench for the 5x7 character generator: directed and random requests.
module tb_text_glyph_renderer;

	localparam int DISPLAY_COLUMNS = 128;
	localparam int DISPLAY_PAGES   = 8;

	// Request type that the block drops without a result.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Cycles with no transaction on either channel before the run is called hung.
	localparam int HANG_LIMIT = 2000;
	// Cycles to wait after the last result, enough to catch stray transactions.
	localparam int SETTLE_CYCLES = 40;

	// 5x7 font for codes 32..90; column 0 sits in the top byte.
	localparam bit [39:0] FONT_COLUMNS [0:58] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_56_20_50, 40'h00_08_07_03_00,
		40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h2A_1C_7F_1C_2A, 40'h08_08_3E_08_08,
		40'h00_80_70_30_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00, 40'h20_10_08_04_02,
		40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h72_49_49_49_46, 40'h21_41_49_4D_33,
		40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_31, 40'h41_21_11_09_07,
		40'h36_49_49_49_36, 40'h46_49_49_29_1E, 40'h00_00_14_00_00, 40'h00_40_34_00_00,
		40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_59_09_06,
		40'h3E_41_5D_59_4E, 40'h7C_12_11_12_7C, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
		40'h7F_41_41_41_3E, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_41_51_73,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
		40'h7F_40_40_40_40, 40'h7F_02_1C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
		40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h26_49_49_49_32,
		40'h03_01_7F_01_03, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
		40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_59_49_4D_43
	};

	logic clk;
	logic arst_n;

	tgr_req_if req_ch ();
	tgr_res_if res_ch ();

	text_glyph_renderer #(
		.DISPLAY_COLUMNS(DISPLAY_COLUMNS),
		.DISPLAY_PAGES  (DISPLAY_PAGES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch)
	);

	// Shadow of the block's text cursor, advanced as requests are accepted.
	logic [7:0] cursor_column;
	logic [7:0] cursor_page;

	// Glyphs the block owes us, oldest first.
	tgr_pkg::res_t glyphs_due[$];

	int  mismatches;
	int  quiet_cycles;
	int  stall_left;
	// Random gaps on the request side and stalls on the result side.
	bit  idle_on;

	// Free-running clock, period 10.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------------------------
	// Reference behavior
	// ---------------------------------------------------------------------------------

	// Look up the five font columns; codes without a glyph fall back to a space.
	function automatic bit [39:0] font_columns(logic [7:0] code);
		if (code < tgr_pkg::FIRST_CODE || code > tgr_pkg::LAST_CODE)
			return FONT_COLUMNS[0];
		return FONT_COLUMNS[code - tgr_pkg::FIRST_CODE];
	endfunction

	// Queue the glyph drawn at the cursor, then advance the cursor column, clamping
	// at the right edge; a column already at or past the edge stays put.
	function automatic void render_glyph(logic [7:0] code, bit last);
		tgr_pkg::res_t glyph;
		bit [39:0]     cols;
		int unsigned   col;
		col = {24'd0, cursor_column};
		cols = font_columns(code);
		glyph.target_page  = cursor_page;
		glyph.start_column = cursor_column;
		glyph.glyph_col0   = cols[39:32];
		glyph.glyph_col1   = cols[31:24];
		glyph.glyph_col2   = cols[23:16];
		glyph.glyph_col3   = cols[15:8];
		glyph.glyph_col4   = cols[7:0];
		glyph.write_mask   = '0;
		// Five glyph columns and the spacer all get the same in-buffer test.
		if (cursor_page < DISPLAY_PAGES) begin
			for (int j = 0; j < 6; j++)
				if (col + j < DISPLAY_COLUMNS)
					glyph.write_mask[j] = 1'b1;
		end
		glyph.last_char = last;
		glyphs_due.push_back(glyph);
		if (col < DISPLAY_COLUMNS)
			cursor_column = 8'((col + 6 > DISPLAY_COLUMNS) ? DISPLAY_COLUMNS : col + 6);
	endfunction

	// Work out every glyph one accepted request causes.
	function automatic void render_request(tgr_pkg::req_t item);
		logic [31:0] magnitude;
		logic [3:0]  digits [10];
		int          count;
		bit          negative;
		case (item.req_type)
			tgr_pkg::REQ_SET_CURSOR: begin
				// Take both values as given, even out of range.
				cursor_column = item.new_column;
				cursor_page   = item.new_page;
			end
			tgr_pkg::REQ_DRAW_CHAR: begin
				render_glyph(item.char_code, 1'b1);
			end
			tgr_pkg::REQ_DRAW_NUM: begin
				negative  = item.number_value[31];
				// Unsigned negate, so the most negative value keeps its full magnitude.
				magnitude = negative ? 32'd0 - $unsigned(item.number_value)
				                     : $unsigned(item.number_value);
				count = 0;
				do begin
					digits[count] = 4'(magnitude % 10);
					magnitude     = magnitude / 10;
					count++;
				end while (magnitude != 0 && count < 10);
				if (negative)
					render_glyph(tgr_pkg::CODE_MINUS, 1'b0);
				for (int k = count - 1; k >= 0; k--)
					render_glyph(tgr_pkg::CODE_ZERO + digits[k], k == 0);
			end
			default: begin
				// Unused type: drop, no glyph, cursor untouched.
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------------------

	// Drive one request and hold it until accepted. Valid stays high afterwards so
	// back-to-back requests need no second assignment in the same step; drop it with
	// release_request when the stream pauses.
	task automatic send_request(input tgr_pkg::req_t item);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		render_request(item);
	endtask

	// Call only in the step of the last acceptance.
	task automatic release_request();
		req_ch.valid <= 1'b0;
	endtask

	// Fill the unused fields with noise so every bit toggles.
	function automatic tgr_pkg::req_t noise_request(logic [1:0] kind);
		tgr_pkg::req_t item;
		item.req_type     = kind;
		item.new_column   = 8'($urandom_range(0, 255));
		item.new_page     = 8'($urandom_range(0, 255));
		item.char_code    = 8'($urandom_range(0, 255));
		item.number_value = $urandom;
		return item;
	endfunction

	function automatic tgr_pkg::req_t cursor_request(logic [7:0] column, logic [7:0] page);
		tgr_pkg::req_t item;
		item = noise_request(tgr_pkg::REQ_SET_CURSOR);
		item.new_column = column;
		item.new_page   = page;
		return item;
	endfunction

	function automatic tgr_pkg::req_t char_request(logic [7:0] code);
		tgr_pkg::req_t item;
		item = noise_request(tgr_pkg::REQ_DRAW_CHAR);
		item.char_code = code;
		return item;
	endfunction

	function automatic tgr_pkg::req_t number_request(logic signed [31:0] value);
		tgr_pkg::req_t item;
		item = noise_request(tgr_pkg::REQ_DRAW_NUM);
		item.number_value = value;
		return item;
	endfunction

	// Random number with an even spread of digit counts and the odd extreme.
	function automatic logic signed [31:0] random_number();
		int unsigned       limit;
		logic signed [31:0] value;
		case ($urandom_range(0, 3))
			0: value = $urandom;
			1: value = $urandom_range(0, 99);
			2: begin
				limit = 10;
				repeat ($urandom_range(0, 8)) limit = limit * 10;
				value = $urandom_range(0, limit - 1);
			end
			default: begin
				case ($urandom_range(0, 4))
					0: value = 32'sh7FFF_FFFF;
					1: value = 32'sh8000_0000;
					2: value = 0;
					3: value = 1_000_000_000;
					default: value = 999_999_999;
				endcase
			end
		endcase
		if ($urandom_range(0, 1) == 1)
			value = -value;
		return value;
	endfunction

	// Mostly text at sensible cursor positions; now and then the full field ranges.
	function automatic tgr_pkg::req_t random_request();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			if ($urandom_range(0, 4) == 0)
				return cursor_request(8'($urandom_range(0, 255)),
				                      8'($urandom_range(0, 255)));
			return cursor_request(8'($urandom_range(0, 130)), 8'($urandom_range(0, 9)));
		end
		if (pick < 58) begin
			if ($urandom_range(0, 4) == 0)
				return char_request(8'($urandom_range(0, 255)));
			return char_request(8'($urandom_range(tgr_pkg::FIRST_CODE, tgr_pkg::LAST_CODE)));
		end
		if (pick < 95)
			return number_request(random_number());
		return noise_request(REQ_UNUSED);
	endfunction

	// ---------------------------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------------------------

	// Stall the result channel in random bursts while idling is on.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 18);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic check_field(input string field, input int unsigned want,
	                           input int unsigned got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Compare every glyph transaction against the oldest one due.
	always @(posedge clk) begin
		tgr_pkg::res_t want;
		tgr_pkg::res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.payload;
			if (glyphs_due.size() == 0) begin
				$display("%0t: unexpected glyph, expected none, actual %0h", $time, got);
				mismatches++;
			end else begin
				want = glyphs_due.pop_front();
				check_field("target_page",  want.target_page,  got.target_page);
				check_field("start_column", want.start_column, got.start_column);
				check_field("glyph_col0",   want.glyph_col0,   got.glyph_col0);
				check_field("glyph_col1",   want.glyph_col1,   got.glyph_col1);
				check_field("glyph_col2",   want.glyph_col2,   got.glyph_col2);
				check_field("glyph_col3",   want.glyph_col3,   got.glyph_col3);
				check_field("glyph_col4",   want.glyph_col4,   got.glyph_col4);
				check_field("write_mask",   want.write_mask,   got.write_mask);
				check_field("last_char",    want.last_char,    got.last_char);
			end
		end
	end

	// Hang detector: end the run once nothing has moved on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d glyphs still due",
				         $time, HANG_LIMIT, glyphs_due.size());
				$display("text_glyph_renderer verification failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------

	// Draw from the reset cursor: both ends of the font, codes just outside it, and
	// all-zero and all-one codes, which fall back to a space.
	task automatic test_character_codes();
		send_request(char_request(8'd0));
		send_request(char_request(tgr_pkg::FIRST_CODE - 8'd1));
		send_request(char_request(tgr_pkg::FIRST_CODE));
		send_request(char_request(tgr_pkg::LAST_CODE));
		send_request(char_request(tgr_pkg::LAST_CODE + 8'd1));
		send_request(char_request(8'hFF));
	endtask

	// Walk the cursor into the right edge: the spacer falls off first, then the glyph
	// columns, then the column pins at the edge and further characters leave it there.
	task automatic test_right_edge();
		send_request(cursor_request(8'd123, 8'd2));
		send_request(char_request("A"));
		send_request(char_request("B"));
		send_request(char_request("C"));
		send_request(cursor_request(8'd125, 8'd0));
		send_request(char_request("Z"));
		send_request(cursor_request(8'hFF, 8'hFF));
		send_request(char_request("Q"));
	endtask

	// A page below the buffer draws with an empty mask but still moves the cursor.
	task automatic test_page_range();
		send_request(cursor_request(8'd5, 8'(DISPLAY_PAGES)));
		send_request(char_request("M"));
		send_request(char_request("N"));
		send_request(cursor_request(8'd0, 8'(DISPLAY_PAGES - 1)));
	endtask

	// Zero, minus one and both ends of the 32-bit range.
	task automatic test_number_text();
		send_request(number_request(0));
		send_request(number_request(-1));
		send_request(number_request(32'sh7FFF_FFFF));
		send_request(number_request(32'sh8000_0000));
	endtask

	// The unused request type must leave no glyph and no cursor change behind.
	task automatic test_unused_request();
		send_request(noise_request(REQ_UNUSED));
		send_request(char_request("0"));
	endtask

	// Random traffic in chunks, alternating stretches with and without idling; the last
	// chunks run flat out.
	task automatic test_random_traffic();
		for (int chunk = 0; chunk < 11; chunk++) begin
			idle_on = (chunk < 9) && (chunk % 3 != 1);
			repeat (40) send_request(random_request());
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		res_ch.ready   = 1'b0;
		cursor_column  = '0;
		cursor_page    = '0;
		mismatches     = 0;
		quiet_cycles   = 0;
		stall_left     = 0;
		idle_on        = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_character_codes();
		test_right_edge();
		test_page_range();
		test_number_text();
		test_unused_request();
		test_random_traffic();
		release_request();

		// Drain the glyphs still due, then watch for strays.
		while (glyphs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("text_glyph_renderer verification clean");
		else
			$display("text_glyph_renderer verification failed");
		$finish;
	end

endmodule
